// ----- hw/rtl/multi_type_unit_allocator_core_defines.svh -----
// Assertion macros for the multi-type unit allocator.
// No dependencies; included by the checker.
`ifndef MULTI_TYPE_UNIT_ALLOCATOR_CORE_DEFINES_SVH
`define MULTI_TYPE_UNIT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define MTUA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtua assertion failed");

// next-cycle implication
`define MTUA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtua assertion failed");

`endif

// ----- hw/rtl/mtua_pkg.sv -----
// Types and constants for the multi-type unit allocator.
// No dependencies.
package mtua_pkg;

   localparam int NUM_TYPES_DEF        = 8;
   localparam int MAX_UNITS_DEF        = 15;
   localparam int MAX_REQUIREMENTS_DEF = 16;

   localparam int RT_W      = 3;
   localparam int QTY_W     = 4;
   localparam int FI_W      = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 4;

   typedef enum logic {
      OP_ACQUIRE = 1'b0,
      OP_RELEASE = 1'b1
   } opcode_type;

   typedef enum logic {
      ST_GRANTED = 1'b0,
      ST_FAILED  = 1'b1
   } status_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [RT_W-1:0]   resource_type;
      logic [QTY_W-1:0]  quantity;
      logic              last_of_request;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [FI_W-1:0]   failed_index;
   } rsp_type;

endpackage

// ----- hw/rtl/multi_type_unit_allocator_core.sv -----
// Multi-type unit allocator: all-or-nothing grants over per-type unit pools.
// An accepted item is registered in stg_req_ff/stg_valid_ff; rsp_valid and the
// result beat are registered from it in rsp_valid_ff and rsp_ff.
// Throughput: one item per cycle; busy stays low, one pass through the
// per-type compare/subtract lanes between the input and result registers.
// Reset (synchronous, active high) clears unit counts, free counts, takes
// and the request state. The receiver cannot stall.
module multi_type_unit_allocator_core #(
   parameter int NUM_TYPES        = mtua_pkg::NUM_TYPES_DEF,
   parameter int MAX_UNITS        = mtua_pkg::MAX_UNITS_DEF,
   parameter int MAX_REQUIREMENTS = mtua_pkg::MAX_REQUIREMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mtua_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output mtua_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [mtua_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mtua_pkg::CSR_W-1:0]          csr_wdata
);
   import mtua_pkg::*;

   localparam int CNT_W = $clog2(MAX_UNITS + 1);
   localparam int EXT_W = ((CNT_W > QTY_W) ? CNT_W : QTY_W) + 1;
   localparam int POS_W = (MAX_REQUIREMENTS > 1) ? $clog2(MAX_REQUIREMENTS) : 1;
   localparam logic [EXT_W-1:0] MAX_UNITS_EXT = EXT_W'(MAX_UNITS);
   localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(MAX_REQUIREMENTS - 1);

   logic                   stg_valid_ff;
   req_type                stg_req_ff;

   logic [CNT_W-1:0]       units_ff [NUM_TYPES];
   logic [CNT_W-1:0]       free_ff  [NUM_TYPES];
   logic [CNT_W-1:0]       tent_ff  [NUM_TYPES];
   logic [CNT_W-1:0]       units_in [NUM_TYPES];
   logic [CNT_W-1:0]       free_in  [NUM_TYPES];
   logic [CNT_W-1:0]       tent_in  [NUM_TYPES];

   logic                   failed_ff, failed_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [POS_W-1:0]       first_ff, first_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [NUM_TYPES-1:0]   sel;
   logic [NUM_TYPES-1:0]   over;
   logic                   is_acq, is_rel, shortfall, fail_now, end_req;
   logic [EXT_W-1:0]       qty_ext, cfg_ext;
   logic [CNT_W-1:0]       cfg_val;
   logic [FI_W+POS_W-1:0]  fi_ext;

   assign busy = 1'b0;

   assign qty_ext = EXT_W'(stg_req_ff.quantity);
   assign cfg_ext = EXT_W'(csr_wdata);
   assign cfg_val = (cfg_ext > MAX_UNITS_EXT) ? CNT_W'(MAX_UNITS) : CNT_W'(csr_wdata);

   assign is_acq = stg_valid_ff && (stg_req_ff.opcode == OP_ACQUIRE);
   assign is_rel = stg_valid_ff && (stg_req_ff.opcode == OP_RELEASE);

   always_comb begin
      for (int i = 0; i < NUM_TYPES; i++) begin
         sel[i]  = (stg_req_ff.resource_type == RT_W'(i));
         over[i] = qty_ext > EXT_W'(free_ff[i]);
      end
   end

   assign shortfall = is_acq && !failed_ff &&
                      ((|(sel & over)) || (!(|sel) && (stg_req_ff.quantity != '0)));
   assign fail_now  = failed_ff || shortfall;
   assign end_req   = is_acq && stg_req_ff.last_of_request;

   // per-type lanes
   always_comb begin
      logic [EXT_W-1:0] sum;
      for (int i = 0; i < NUM_TYPES; i++) begin
         sum         = '0;
         units_in[i] = units_ff[i];
         free_in[i]  = free_ff[i];
         tent_in[i]  = tent_ff[i];
         if (is_rel && sel[i]) begin
            sum = EXT_W'(free_ff[i]) + qty_ext;
            free_in[i] = (sum > EXT_W'(units_ff[i])) ? units_ff[i] : CNT_W'(sum);
         end
         if (is_acq && !failed_ff && sel[i] && !over[i] && (stg_req_ff.quantity != '0)) begin
            sum = EXT_W'(free_ff[i]) - qty_ext;
            free_in[i] = CNT_W'(sum);
            sum = EXT_W'(tent_ff[i]) + qty_ext;
            tent_in[i] = (sum > MAX_UNITS_EXT) ? CNT_W'(MAX_UNITS) : CNT_W'(sum);
         end
         if (end_req) begin
            if (fail_now) begin
               sum = EXT_W'(free_in[i]) + EXT_W'(tent_in[i]);
               free_in[i] = (sum > EXT_W'(units_ff[i])) ? units_ff[i] : CNT_W'(sum);
            end
            tent_in[i] = '0;
         end
         if (csr_we && (csr_index == CSR_IDX_W'(i))) begin
            units_in[i] = cfg_val;
            free_in[i]  = cfg_val;
            tent_in[i]  = '0;
         end
      end
   end

   // request tracking
   always_comb begin
      failed_in = failed_ff;
      pos_in    = pos_ff;
      first_in  = first_ff;
      if (is_acq) begin
         if (shortfall) begin
            failed_in = 1'b1;
            first_in  = pos_ff;
         end
         if (pos_ff < POS_LIMIT) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (stg_req_ff.last_of_request) begin
            failed_in = 1'b0;
            pos_in    = '0;
            first_in  = '0;
         end
      end
   end

   assign fi_ext = {{FI_W{1'b0}}, (failed_ff ? first_ff : pos_ff)};

   always_comb begin
      rsp_valid_in        = end_req;
      rsp_in.status       = fail_now ? ST_FAILED : ST_GRANTED;
      rsp_in.failed_index = fail_now ? fi_ext[FI_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         failed_ff    <= 1'b0;
         pos_ff       <= '0;
         first_ff     <= '0;
         for (int i = 0; i < NUM_TYPES; i++) begin
            units_ff[i] <= '0;
            free_ff[i]  <= '0;
            tent_ff[i]  <= '0;
         end
      end else begin
         stg_valid_ff <= start && !busy;
         rsp_valid_ff <= rsp_valid_in;
         failed_ff    <= failed_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         for (int i = 0; i < NUM_TYPES; i++) begin
            units_ff[i] <= units_in[i];
            free_ff[i]  <= free_in[i];
            tent_ff[i]  <= tent_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         stg_req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/mtua_checker.sv -----
// Port-level checks for multi_type_unit_allocator_core, bound to the top level.
// Depends on mtua_pkg and multi_type_unit_allocator_core_defines.svh.
`include "multi_type_unit_allocator_core_defines.svh"

module mtua_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input mtua_pkg::req_type               req_data,
   input logic                            rsp_valid,
   input mtua_pkg::rsp_type               rsp_data,
   input logic                            csr_we,
   input logic [mtua_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [mtua_pkg::CSR_W-1:0]      csr_wdata
);
   import mtua_pkg::*;

   logic acc;
   logic cfg_seen;

   assign acc      = start && !busy;
   assign cfg_seen = csr_we && (csr_index == csr_index) && (csr_wdata == csr_wdata);

   `MTUA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
   `MTUA_ASSERT_NEXT(a_release_silent, clock, reset, acc && req_data.opcode == OP_RELEASE, ##1 !rsp_valid)
   `MTUA_ASSERT_NEXT(a_mid_request_silent, clock, reset, !acc || !req_data.last_of_request || cfg_seen, ##1 (!rsp_valid || $past(acc, 2) || cfg_seen))
   `MTUA_ASSERT_NOW(a_grant_index_zero, clock, reset, rsp_valid && rsp_data.status == ST_GRANTED, rsp_data.failed_index == '0)

endmodule

bind multi_type_unit_allocator_core mtua_checker u_mtua_checker (.*);
